// ===== rtl/gcne_pkg.sv =====
// ---------------------------------------------------------------------------
// gcne_pkg
// Shared types, widths and candidate offset tables of the grid cell
// neighbour enumerator.
// ---------------------------------------------------------------------------
package gcne_pkg;

  localparam int ID_W    = 30;
  localparam int CFG_W   = 11;
  localparam int NCAND   = 27;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DIMS = 2'd0,
    REG_LEN0 = 2'd1,
    REG_LEN1 = 2'd2,
    REG_LEN2 = 2'd3
  } reg_idx_e;

  // per dimension d: bit 2d = step -1, bit 2d+1 = step +1
  typedef logic [5:0] off_t;
  typedef off_t cand_tab_t [NCAND];

  // item handed to the enumerator
  typedef struct packed {
    logic             bad;
    logic             op;
    logic [NCAND-1:0] mask;
    logic [ID_W-1:0]  base;
    logic [ID_W-1:0]  s1;
    logic [ID_W-1:0]  s2;
  } item_t;

  function automatic cand_tab_t mk_tab(input logic face);
    cand_tab_t t;
    int        idx;
    off_t      o;
    idx = 0;
    for (int k = 0; k < NCAND; k++) t[k] = '0;
    if (face) begin
      for (int d = 0; d < 3; d++) begin
        for (int s = 0; s < 2; s++) begin
          t[2*d+s] = off_t'(1) << (2*d + s);
        end
      end
    end else begin
      // dimension 0 slowest, each offset -1, 0, +1
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          for (int e = 0; e < 3; e++) begin
            o = '0;
            if (a == 0) o[0] = 1'b1;
            if (a == 2) o[1] = 1'b1;
            if (b == 0) o[2] = 1'b1;
            if (b == 2) o[3] = 1'b1;
            if (e == 0) o[4] = 1'b1;
            if (e == 2) o[5] = 1'b1;
            t[idx] = o;
            idx++;
          end
        end
      end
    end
    return t;
  endfunction

  localparam cand_tab_t FACE_TAB = mk_tab(1'b1);
  localparam cand_tab_t ALL_TAB  = mk_tab(1'b0);

endpackage

// ===== rtl/gcne_if.sv =====
// ---------------------------------------------------------------------------
// gcne channel interfaces
// Valid/ready channels for queries, results and register writes.
// ---------------------------------------------------------------------------
interface gcne_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [gcne_pkg::ID_W-1:0] cell_id;
  modport source (output valid, op, cell_id, input ready);
  modport sink (input valid, op, cell_id, output ready);
endinterface

interface gcne_out_if;
  logic                      valid;
  logic                      ready;
  logic [gcne_pkg::ID_W-1:0] neighbour_id;
  logic                      found;
  logic                      bad_id;
  logic                      last;
  modport source (output valid, neighbour_id, found, bad_id, last, input ready);
  modport sink (input valid, neighbour_id, found, bad_id, last, output ready);
endinterface

interface gcne_cfg_if;
  logic                       valid;
  logic                       ready;
  gcne_pkg::reg_idx_e         index;
  logic [gcne_pkg::CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gcne_div.sv =====
// ---------------------------------------------------------------------------
// gcne_div
// Pipelined restoring divider, STEP quotient bits per stage, with sideband.
// ---------------------------------------------------------------------------
module gcne_div #(
  parameter int NUM_W  = 30,
  parameter int DEN_W  = 11,
  parameter int STEP   = 6,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int NS = (NUM_W + STEP - 1) / STEP;
  localparam int PW = NS * STEP;

  logic              v_q    [NS];
  logic [DEN_W-1:0]  rem_q  [NS];
  logic [PW-1:0]     nq_q   [NS];
  logic [DEN_W-1:0]  den_q  [NS];
  logic [SIDE_W-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [PW-1:0]     nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W-1:0]  rem_d;
    logic [PW-1:0]     nq_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign nq_in   = PW'(num_i);
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_comb begin
      logic [DEN_W:0] r;
      rem_d = rem_in;
      nq_d  = nq_in;
      for (int s = 0; s < STEP; s++) begin
        r    = {rem_d, nq_d[PW-1]};
        nq_d = {nq_d[PW-2:0], 1'b0};
        if (r >= {1'b0, den_in}) begin
          rem_d   = DEN_W'(r - {1'b0, den_in});
          nq_d[0] = 1'b1;
        end else begin
          rem_d = r[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        nq_q[k]   <= nq_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quo_o   = NUM_W'(nq_q[NS-1]);
  assign rem_o   = rem_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// ===== rtl/gcne_enum.sv =====
// ---------------------------------------------------------------------------
// gcne_enum
// Walks the neighbour mask of one item into an output register, one result
// beat per cycle unless the output is held.
// ---------------------------------------------------------------------------
module gcne_enum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  gcne_pkg::item_t      item_i,
  output logic                 item_ready_o,
  gcne_out_if.source           rsp_o
);

  localparam int NC = gcne_pkg::NCAND;
  localparam int IW = gcne_pkg::ID_W;

  logic            busy_q;
  logic            single_q;
  logic            bad_q;
  logic            op_q;
  logic [NC-1:0]   mask_q;
  logic [IW-1:0]   cell_q, s1_q, s2_q;

  logic            out_v_q;
  logic [IW-1:0]   out_id_q;
  logic            out_found_q, out_bad_q, out_last_q;

  logic            out_adv, fire, done, load;
  logic [NC-1:0]   lowbit, rest;
  gcne_pkg::off_t  sel;
  logic [IW-1:0]   d0, d1, d2, nid;

  assign out_adv = !out_v_q || rsp_o.ready;
  assign fire    = busy_q && out_adv;
  assign lowbit  = mask_q & (~mask_q + NC'(1));
  assign rest    = mask_q & (mask_q - NC'(1));
  assign done    = single_q || (rest == '0);

  assign item_ready_o = !busy_q || (fire && done);
  assign load         = item_valid_i && item_ready_o;

  always_comb begin
    sel = '0;
    for (int j = 0; j < NC; j++) begin
      if (lowbit[j]) begin
        sel = sel | (op_q ? gcne_pkg::ALL_TAB[j] : gcne_pkg::FACE_TAB[j]);
      end
    end
  end

  // all sums wrap at the id width
  assign d0  = sel[1] ? IW'(1) : (sel[0] ? '1 : '0);
  assign d1  = sel[3] ? s1_q : (sel[2] ? (~s1_q + IW'(1)) : '0);
  assign d2  = sel[5] ? s2_q : (sel[4] ? (~s2_q + IW'(1)) : '0);
  assign nid = cell_q + d0 + d1 + d2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (fire && done) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      single_q <= item_i.bad || (item_i.mask == '0);
      bad_q    <= item_i.bad;
      op_q     <= item_i.op;
      mask_q   <= item_i.mask;
      cell_q   <= item_i.base;
      s1_q     <= item_i.s1;
      s2_q     <= item_i.s2;
    end else if (fire) begin
      mask_q <= rest;
    end
    if (fire) begin
      if (single_q) begin
        out_id_q    <= '0;
        out_found_q <= 1'b0;
        out_bad_q   <= bad_q;
        out_last_q  <= 1'b1;
      end else begin
        out_id_q    <= nid;
        out_found_q <= 1'b1;
        out_bad_q   <= 1'b0;
        out_last_q  <= done;
      end
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.neighbour_id = out_id_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.bad_id       = out_bad_q;
  assign rsp_o.last         = out_last_q;

endmodule

// ===== rtl/grid_cell_neighbour_enumerator.sv =====
// ---------------------------------------------------------------------------
// grid_cell_neighbour_enumerator
// Splits a linear cell id into grid coordinates and lists its neighbours.
// ---------------------------------------------------------------------------
// A query is taken in any cycle the pipeline is not held. The id passes an
// input stage, two pipelined dividers (one by length_0, one by length_1,
// six quotient bits per stage, five stages each), then three stages that
// form the strides, the cell count and the neighbour mask. The output
// gives one beat per cycle while the receiver is ready: a query gives one
// beat per neighbour (up to 26), or a single beat when it has none or its
// id is out of the grid; the enumerator at the end of the pipeline sets
// the beat count. The user must write registers only while no query is
// in flight; the block itself does not enforce it.
module grid_cell_neighbour_enumerator #(
  parameter int MAX_DIMS    = 3,
  parameter int LENGTH_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcne_in_if.sink     req_i,
  gcne_out_if.source  rsp_o,
  gcne_cfg_if.sink    cfg_i
);

  localparam int IW  = gcne_pkg::ID_W;
  localparam int LW  = LENGTH_BITS + 1;
  localparam int CW  = (3 * LW > IW + 1) ? 3 * LW : IW + 1;
  localparam int CAP = 1 << LENGTH_BITS;
  localparam int SW0 = 1 + IW + 3 * LW;
  localparam int SW1 = SW0 + LW;

  // registers
  logic [1:0]                 dims_q;
  logic [gcne_pkg::CFG_W-1:0] len0_q, len1_q, len2_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 2'd2;
      len0_q <= gcne_pkg::CFG_W'(16);
      len1_q <= gcne_pkg::CFG_W'(16);
      len2_q <= gcne_pkg::CFG_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gcne_pkg::REG_DIMS: dims_q <= cfg_i.data[1:0];
        gcne_pkg::REG_LEN0: len0_q <= cfg_i.data;
        gcne_pkg::REG_LEN1: len1_q <= cfg_i.data;
        gcne_pkg::REG_LEN2: len2_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  function automatic logic [LW-1:0] eff_len(input logic [gcne_pkg::CFG_W-1:0] raw);
    int unsigned r;
    r = raw;
    if (r == 0) r = 1;
    if (r > CAP) r = CAP;
    return LW'(r);
  endfunction

  int unsigned     nd;
  logic [LW-1:0]   l0_in, l1_in, l2_in;

  always_comb begin
    nd = dims_q;
    if (nd == 0) nd = 1;
    if (nd > MAX_DIMS) nd = MAX_DIMS;
    l0_in = eff_len(len0_q);
    l1_in = (nd >= 2) ? eff_len(len1_q) : LW'(1);
    l2_in = (nd >= 3) ? eff_len(len2_q) : LW'(1);
  end

  // global advance: everything moves unless the last stage is held
  logic            en;
  logic            enum_ready;
  logic            d_v_q;
  gcne_pkg::item_t d_item_q;

  assign en          = !d_v_q || enum_ready;
  assign req_i.ready = en;

  // stage A
  logic            a_v_q, a_op_q;
  logic [IW-1:0]   a_cell_q;
  logic [LW-1:0]   a_l0_q, a_l1_q, a_l2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q   <= req_i.op;
      a_cell_q <= req_i.cell_id;
      a_l0_q   <= l0_in;
      a_l1_q   <= l1_in;
      a_l2_q   <= l2_in;
    end
  end

  // coordinate 0 = id mod length_0
  logic            v0;
  logic [IW-1:0]   q0;
  logic [LW-1:0]   r0;
  logic [SW0-1:0]  side0;
  logic            s0_op;
  logic [IW-1:0]   s0_cell;
  logic [LW-1:0]   s0_l0, s0_l1, s0_l2;

  gcne_div #(.NUM_W(IW), .DEN_W(LW), .STEP(6), .SIDE_W(SW0)) u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_v_q),
    .num_i   (a_cell_q),
    .den_i   (a_l0_q),
    .side_i  ({a_op_q, a_cell_q, a_l0_q, a_l1_q, a_l2_q}),
    .valid_o (v0),
    .quo_o   (q0),
    .rem_o   (r0),
    .side_o  (side0)
  );

  assign {s0_op, s0_cell, s0_l0, s0_l1, s0_l2} = side0;

  // coordinates 1 and 2
  logic            v1;
  logic [IW-1:0]   q1;
  logic [LW-1:0]   r1;
  logic [SW1-1:0]  side1;
  logic            s1_op;
  logic [IW-1:0]   s1_cell;
  logic [LW-1:0]   s1_l0, s1_l1, s1_l2, s1_c0;

  gcne_div #(.NUM_W(IW), .DEN_W(LW), .STEP(6), .SIDE_W(SW1)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0),
    .num_i   (q0),
    .den_i   (s0_l1),
    .side_i  ({side0, r0}),
    .valid_o (v1),
    .quo_o   (q1),
    .rem_o   (r1),
    .side_o  (side1)
  );

  assign {s1_op, s1_cell, s1_l0, s1_l1, s1_l2, s1_c0} = side1;

  // stage B: edge flags and length_0 * length_1
  logic            b_v_q, b_op_q;
  logic [IW-1:0]   b_cell_q;
  logic [LW-1:0]   b_l0_q, b_l2_q;
  logic [2*LW-1:0] b_l01_q;
  logic [2:0]      b_lo_q, b_hi_q;
  logic [LW-1:0]   c2_in;

  // valid ids keep the top quotient below length_2
  assign c2_in = LW'(q1[LENGTH_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_op_q   <= s1_op;
      b_cell_q <= s1_cell;
      b_l0_q   <= s1_l0;
      b_l2_q   <= s1_l2;
      b_l01_q  <= s1_l0 * s1_l1;
      b_lo_q   <= {c2_in != '0, r1 != '0, s1_c0 != '0};
      b_hi_q   <= {({1'b0, c2_in} + (LW+1)'(1)) < {1'b0, s1_l2},
                   ({1'b0, r1} + (LW+1)'(1)) < {1'b0, s1_l1},
                   ({1'b0, s1_c0} + (LW+1)'(1)) < {1'b0, s1_l0}};
    end
  end

  // stage C: strides and cell count
  logic            c_v_q, c_op_q;
  logic [IW-1:0]   c_cell_q, c_s1_q, c_s2_q;
  logic [3*LW-1:0] c_count_q;
  logic [2:0]      c_lo_q, c_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_op_q    <= b_op_q;
      c_cell_q  <= b_cell_q;
      c_s1_q    <= IW'(b_l0_q);
      c_s2_q    <= IW'(b_l01_q);
      c_count_q <= b_l01_q * b_l2_q;
      c_lo_q    <= b_lo_q;
      c_hi_q    <= b_hi_q;
    end
  end

  // stage D: range check and neighbour mask
  gcne_pkg::item_t d_item_d;

  always_comb begin
    gcne_pkg::off_t m;
    logic           ok;
    d_item_d.bad  = CW'(c_cell_q) >= CW'(c_count_q);
    d_item_d.op   = c_op_q;
    d_item_d.base = c_cell_q;
    d_item_d.s1   = c_s1_q;
    d_item_d.s2   = c_s2_q;
    for (int j = 0; j < gcne_pkg::NCAND; j++) begin
      m  = c_op_q ? gcne_pkg::ALL_TAB[j] : gcne_pkg::FACE_TAB[j];
      ok = (m != '0);
      for (int d = 0; d < 3; d++) begin
        ok = ok && (!m[2*d] || c_lo_q[d]) && (!m[2*d+1] || c_hi_q[d]);
      end
      d_item_d.mask[j] = ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_item_q <= d_item_d;
    end
  end

  gcne_enum u_enum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (d_v_q),
    .item_i       (d_item_q),
    .item_ready_o (enum_ready),
    .rsp_o        (rsp_o)
  );

  // out of grid beats are single and carry no neighbour
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.bad_id |-> rsp_o.last && !rsp_o.found)
    else $error("bad id beat not a lone final beat");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.found |-> rsp_o.last && rsp_o.neighbour_id == '0)
    else $error("not-found beat must be last with zero id");

  // a held item at the pipeline tail must not move or vanish
  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v_q && !enum_ready |=> d_v_q && $stable(d_item_q))
    else $error("tail item changed while held");

endmodule
